### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for the RTL files that assert.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/sup_pkg.sv
// ----------------------------------------------------------------------------
// sup_pkg
// Widths, constants and saturating fixed-point helpers for the upmix block.
// ----------------------------------------------------------------------------
package sup_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int FIELD_W      = 32;
    localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
    localparam int DROP_BITS    = FIELD_W - SAMPLE_WIDTH;
    localparam int PROD_W       = 2 * SAMPLE_WIDTH;
    localparam int WIDE_W       = SAMPLE_WIDTH + 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] frac_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [WIDE_W-1:0]       wide_t;
    typedef logic        [FIELD_W-1:0]      field_t;

    localparam frac_t FMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam frac_t FMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Q1.31 constants, floored to the datapath width
    localparam longint Q31_T1 = 107374182;
    localparam longint Q31_T2 = 214748364;
    localparam longint Q31_G  = 1705806895;
    localparam longint Q31_K  = 178956960;
    localparam longint Q31_Q  = 1610612736;

    localparam frac_t T1_K     = frac_t'(Q31_T1 >>> DROP_BITS);
    localparam frac_t T2_K     = frac_t'(Q31_T2 >>> DROP_BITS);
    localparam frac_t NEG_T1_K = frac_t'(-(Q31_T1 >>> DROP_BITS));
    localparam frac_t NEG_T2_K = frac_t'(-(Q31_T2 >>> DROP_BITS));
    localparam frac_t G_K      = frac_t'(Q31_G >>> DROP_BITS);
    localparam frac_t KNEE_K   = frac_t'(Q31_K >>> DROP_BITS);
    localparam frac_t NEG_KNEE = frac_t'(-(Q31_K >>> DROP_BITS));
    localparam frac_t QUAD_K   = frac_t'(Q31_Q >>> DROP_BITS);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_GAIN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE = 1'b1;

    localparam int MODE_W          = 2;
    localparam int MODE_LFE_BIT    = 0;
    localparam int MODE_CENTER_BIT = 1;
    localparam logic [MODE_W-1:0] MODE_RESET = '0;
    localparam field_t GAIN_RESET_FIELD = 32'h7FFF_FFFF;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    function automatic frac_t narrow(field_t f);
        return frac_t'(f[FIELD_W-1 -: SAMPLE_WIDTH]);
    endfunction

    function automatic field_t widen(frac_t v);
        field_t w;
        w = field_t'(v);
        return w << DROP_BITS;
    endfunction

    function automatic wide_t ext(frac_t v);
        return wide_t'(v);
    endfunction

    function automatic frac_t sat(wide_t v);
        if (v > ext(FMAX))
            return FMAX;
        if (v < ext(FMIN))
            return FMIN;
        return frac_t'(v);
    endfunction

    function automatic prod_t mul(frac_t a, frac_t b);
        return a * b;
    endfunction

    // Drop the low fraction bits (floor) and saturate
    function automatic frac_t mul_trunc(prod_t p);
        return sat(wide_t'($signed(p[PROD_W-1:FRAC_BITS])));
    endfunction

    function automatic frac_t sat_add(frac_t a, frac_t b);
        return sat(ext(a) + ext(b));
    endfunction

    function automatic frac_t sat_sub(frac_t a, frac_t b);
        return sat(ext(a) - ext(b));
    endfunction

    function automatic frac_t sat_neg(frac_t a);
        return sat(-ext(a));
    endfunction

    function automatic frac_t shl_sat(frac_t a, int k);
        return sat(ext(a) <<< k);
    endfunction

endpackage

### rtl/sup_gain.sv
// ----------------------------------------------------------------------------
// sup_gain
// Stages 1 and 2: gain multiply of both inputs, then -2 dB scaling products.
// ----------------------------------------------------------------------------
module sup_gain (
    input  logic                clk,
    input  sup_pkg::stage_en_t  en,
    input  sup_pkg::field_t     left_sample,
    input  sup_pkg::field_t     right_sample,
    input  sup_pkg::frac_t      gain,
    output sup_pkg::frac_t      fl,
    output sup_pkg::frac_t      fr,
    output sup_pkg::prod_t      gl_prod,
    output sup_pkg::prod_t      gr_prod
);
    import sup_pkg::*;

    prod_t pl_reg, pl_next;
    prod_t pr_reg, pr_next;
    frac_t fl_reg, fl_next;
    frac_t fr_reg, fr_next;
    prod_t gl_reg, gl_next;
    prod_t gr_reg, gr_next;

    always_comb
    begin
        pl_next = mul(narrow(left_sample), gain);
        pr_next = mul(narrow(right_sample), gain);
        fl_next = mul_trunc(pl_reg);
        fr_next = mul_trunc(pr_reg);
        gl_next = mul(fl_next, G_K);
        gr_next = mul(fr_next, G_K);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pl_reg <= pl_next;
            pr_reg <= pr_next;
        end
        if (en.s2)
        begin
            fl_reg <= fl_next;
            fr_reg <= fr_next;
            gl_reg <= gl_next;
            gr_reg <= gr_next;
        end
    end

    assign fl      = fl_reg;
    assign fr      = fr_reg;
    assign gl_prod = gl_reg;
    assign gr_prod = gr_reg;

endmodule

### rtl/sup_shaper.sv
// ----------------------------------------------------------------------------
// sup_shaper
// Stages 3 to 5: LFE waveshaper with clip, quadratic knee and linear gain.
// ----------------------------------------------------------------------------
module sup_shaper (
    input  logic                clk,
    input  sup_pkg::stage_en_t  en,
    input  sup_pkg::frac_t      x,
    input  logic                lfe_on,
    output sup_pkg::frac_t      lfe
);
    import sup_pkg::*;

    typedef enum logic [4:0] {
        SHP_LIN = 5'b00001,
        SHP_POS = 5'b00010,
        SHP_NEG = 5'b00100,
        SHP_MAX = 5'b01000,
        SHP_MIN = 5'b10000
    } region_t;

    region_t rg3_reg, rg3_next, rg4_reg;
    prod_t   sq_prod_reg, sq_prod_next;
    frac_t   y1_3_reg, y1_3_next, y1_4_reg;
    frac_t   lin3_reg, lin3_next, lin4_reg;
    prod_t   q_prod_reg, q_prod_next;
    frac_t   lfe_reg, lfe_next;
    frac_t   q_val;
    frac_t   shaped;

    // Stage 3: classify, square, start the knee sum
    always_comb
    begin
        if (x > T2_K)
            rg3_next = SHP_MAX;
        else if (x > T1_K)
            rg3_next = SHP_POS;
        else if (x < NEG_T2_K)
            rg3_next = SHP_MIN;
        else if (x < NEG_T1_K)
            rg3_next = SHP_NEG;
        else
            rg3_next = SHP_LIN;
        sq_prod_next = mul(x, x);
        y1_3_next    = (x > T1_K) ? sat_add(NEG_KNEE, x) : sat_add(KNEE_K, x);
        lin3_next    = shl_sat(x, 1);
    end

    // Stage 4: scale the square
    always_comb
    begin
        q_prod_next = mul(QUAD_K, mul_trunc(sq_prod_reg));
    end

    // Stage 5: finish the knee and pick the region
    always_comb
    begin
        q_val = mul_trunc(q_prod_reg);
        case (rg4_reg)
            SHP_POS: shaped = shl_sat(sat_sub(y1_4_reg, q_val), 2);
            SHP_NEG: shaped = shl_sat(sat_add(y1_4_reg, q_val), 2);
            SHP_MAX: shaped = FMAX;
            SHP_MIN: shaped = FMIN;
            SHP_LIN: shaped = lin4_reg;
            default: shaped = lin4_reg;
        endcase
        if (lfe_on)
            lfe_next = shaped >>> 1;
        else
            lfe_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            rg3_reg     <= rg3_next;
            sq_prod_reg <= sq_prod_next;
            y1_3_reg    <= y1_3_next;
            lin3_reg    <= lin3_next;
        end
        if (en.s4)
        begin
            rg4_reg    <= rg3_reg;
            q_prod_reg <= q_prod_next;
            y1_4_reg   <= y1_3_reg;
            lin4_reg   <= lin3_reg;
        end
        if (en.s5)
        begin
            lfe_reg <= lfe_next;
        end
    end

    assign lfe = lfe_reg;

endmodule

### rtl/stereo_to_surround_upmix_lfe_clip.sv
// ----------------------------------------------------------------------------
// stereo_to_surround_upmix_lfe_clip
// Stereo to 5.1 upmix: gain, negated surrounds, centre sum, waveshaped LFE.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one left/right Q1.31 pair (in_valid, in_stall).
//   Output requests carry one six-channel frame (out_valid, out_stall).
//   Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) set
//   master_gain (index 0) and output_mode (index 1); cfg_ready is always
//   high. Write them only while no request is in flight.
//   Pipeline: five register stages, s1 to s5; a frame is valid once the
//   last stage takes it. Throughput: one request per cycle while out_stall
//   is low; each stage holds at most one multiply per channel.
//   Reset clears all stage valids, sets master_gain to max fraction and
//   output_mode to 2/2/0. Data registers are not reset.
//   When the receiver stalls, the last stage holds its frame and earlier
//   stages fill bubbles; in_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_to_surround_upmix_lfe_clip (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  sup_pkg::field_t                        left_sample,
    input  sup_pkg::field_t                        right_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output sup_pkg::field_t                        front_left_out,
    output sup_pkg::field_t                        front_right_out,
    output sup_pkg::field_t                        surround_left_out,
    output sup_pkg::field_t                        surround_right_out,
    output sup_pkg::field_t                        center_out,
    output sup_pkg::field_t                        lfe_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sup_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  sup_pkg::field_t                        cfg_data
);
    import sup_pkg::*;

    // Configuration
    frac_t             gain_reg, gain_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    // Stage valids and enables
    logic      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    stage_en_t en;

    // Datapath between the gain stages and the outputs
    frac_t fl, fr;
    prod_t gl_prod, gr_prod;
    frac_t sl, sr;
    frac_t lfe;

    frac_t fl3_reg, fl3_next, fr3_reg, fr3_next;
    frac_t srl3_reg, srl3_next, srr3_reg, srr3_next;
    frac_t c3_reg, c3_next;
    frac_t fl4_reg, fr4_reg, srl4_reg, srr4_reg, c4_reg;
    frac_t fl5_reg, fr5_reg, srl5_reg, srr5_reg, c5_reg;

    // Always ready; the datapath sees it when idle only if the user writes then.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        gain_next = gain_reg;
        mode_next = mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MASTER_GAIN)
                gain_next = narrow(cfg_data);
            else if (cfg_index == CFG_OUTPUT_MODE)
                mode_next = cfg_data[MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= narrow(GAIN_RESET_FIELD);
            mode_reg <= MODE_RESET;
        end
        else
        begin
            gain_reg <= gain_next;
            mode_reg <= mode_next;
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    // Bubbles collapse under a stall, so nothing is lost or repeated.
    always_comb
    begin
        en.s5 = !v5_reg || !out_stall;
        en.s4 = !v4_reg || en.s5;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign in_stall = !en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= in_valid;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en.s3)
                v3_reg <= v2_reg;
            if (en.s4)
                v4_reg <= v3_reg;
            if (en.s5)
                v5_reg <= v4_reg;
        end
    end

    // Stages 1-2: gain and -2 dB products
    sup_gain u_gain (
        .clk          (clk),
        .en           (en),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .gain         (gain_reg),
        .fl           (fl),
        .fr           (fr),
        .gl_prod      (gl_prod),
        .gr_prod      (gr_prod)
    );

    // Stage 3: finish scaling, form surrounds and centre
    always_comb
    begin
        sl        = mul_trunc(gl_prod);
        sr        = mul_trunc(gr_prod);
        fl3_next  = fl;
        fr3_next  = fr;
        srl3_next = sat_neg(fl);
        srr3_next = sat_neg(fr);
        c3_next   = mode_reg[MODE_CENTER_BIT] ? sat_add(sl, sr) : '0;
    end

    // Stages 3-5: LFE waveshaper on the scaled right sample
    sup_shaper u_shaper (
        .clk    (clk),
        .en     (en),
        .x      (sr),
        .lfe_on (mode_reg[MODE_LFE_BIT]),
        .lfe    (lfe)
    );

    // Delay the plain channels alongside the shaper
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            fl3_reg  <= fl3_next;
            fr3_reg  <= fr3_next;
            srl3_reg <= srl3_next;
            srr3_reg <= srr3_next;
            c3_reg   <= c3_next;
        end
        if (en.s4)
        begin
            fl4_reg  <= fl3_reg;
            fr4_reg  <= fr3_reg;
            srl4_reg <= srl3_reg;
            srr4_reg <= srr3_reg;
            c4_reg   <= c3_reg;
        end
        if (en.s5)
        begin
            fl5_reg  <= fl4_reg;
            fr5_reg  <= fr4_reg;
            srl5_reg <= srl4_reg;
            srr5_reg <= srr4_reg;
            c5_reg   <= c4_reg;
        end
    end

    assign out_valid          = v5_reg;
    assign front_left_out     = widen(fl5_reg);
    assign front_right_out    = widen(fr5_reg);
    assign surround_left_out  = widen(srl5_reg);
    assign surround_right_out = widen(srr5_reg);
    assign center_out         = widen(c5_reg);
    assign lfe_out            = widen(lfe);

    // Input backpressure only when every stage is full and the output waits
    `ASSERT_CLK(a_stall_full,
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && out_stall),
        "in_stall raised with a bubble in the pipeline")
    // Disabled centre produces silence
    `ASSERT_CLK(a_center_off,
        (out_valid && !mode_reg[MODE_CENTER_BIT]) |-> (center_out == '0),
        "center_out nonzero with centre disabled")
    // Disabled LFE produces silence
    `ASSERT_CLK(a_lfe_off,
        (out_valid && !mode_reg[MODE_LFE_BIT]) |-> (lfe_out == '0),
        "lfe_out nonzero with LFE disabled")
    // Reset empties the pipeline
    `ASSERT_RST(a_reset_empty,
        !rst_n |=> !out_valid,
        "out_valid high right after reset")

endmodule
